>>> rtl/avm_pkg.sv
// Shared constants for the accelerometer vector magnitude unit.
`timescale 1ns / 1ps

package avm_pkg;

  // Fixed port widths
  localparam int IN_W   = 16;
  localparam int OUT_W  = 20;
  localparam int GREF_W = 16;

  // Parameter defaults
  localparam int FRAC_BITS_DEF   = 4;
  localparam int SAMPLE_BITS_DEF = 16;

  // Gravity reference after reset, in raw counts
  localparam logic [GREF_W-1:0] GREF_RESET = 16'd16384;

  // Saturation limit of the result fields
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

endpackage

>>> rtl/avm_front.sv
// Front pipeline: axis absolute values, squares and sum of squares.
`timescale 1ns / 1ps

module avm_front #(
  parameter int SAMPLE_BITS = avm_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = 2 * SAMPLE_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [avm_pkg::IN_W-1:0] axis_x,
  input  logic [avm_pkg::IN_W-1:0] axis_y,
  input  logic [avm_pkg::IN_W-1:0] axis_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SUM_W-1:0]        out_sum
);

  localparam int S_W  = SAMPLE_BITS;
  localparam int SQ_W = 2 * SAMPLE_BITS;

  // Absolute value of the low SAMPLE_BITS bits, read as two's complement
  function automatic logic [S_W-1:0] abs_f(input logic [avm_pkg::IN_W-1:0] raw);
    logic [S_W-1:0] v;
    v = raw[S_W-1:0];
    if (v[S_W-1]) begin
      v = (~v) + {{(S_W-1){1'b0}}, 1'b1};
    end
    return v;
  endfunction

  logic            v0_r, v1_r, v2_r;
  logic            v0_nxt, v1_nxt, v2_nxt;
  logic            rdy0, rdy1, rdy2;
  logic [S_W-1:0]  ax_r, ay_r, az_r;
  logic [S_W-1:0]  ax_nxt, ay_nxt, az_nxt;
  logic [SQ_W-1:0] sqx_r, sqy_r, sqz_r;
  logic [SQ_W-1:0] sqx_nxt, sqy_nxt, sqz_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // Stage ready chain: a stage takes data when empty or draining
  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  // Stage datapaths
  always_comb begin
    ax_nxt  = abs_f(axis_x);
    ay_nxt  = abs_f(axis_y);
    az_nxt  = abs_f(axis_z);
    sqx_nxt = SQ_W'(ax_r) * SQ_W'(ax_r);
    sqy_nxt = SQ_W'(ay_r) * SQ_W'(ay_r);
    sqz_nxt = SQ_W'(az_r) * SQ_W'(az_r);
    sum_nxt = SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);
  end

  // Advance valid bits
  always_comb begin
    v0_nxt = rdy0 ? in_valid : v0_r;
    v1_nxt = rdy1 ? v0_r : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  // Load payload on each stage transfer
  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      az_r <= az_nxt;
    end
    if (rdy1 && v0_r) begin
      sqx_r <= sqx_nxt;
      sqy_r <= sqy_nxt;
      sqz_r <= sqz_nxt;
    end
    if (rdy2 && v1_r) begin
      sum_r <= sum_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_sum   = sum_r;

endmodule

>>> rtl/avm_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module avm_sqrt #(
  parameter int SAMPLE_BITS = avm_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = avm_pkg::FRAC_BITS_DEF,
  parameter int SUM_W       = 2 * SAMPLE_BITS,
  parameter int ROOT_W      = SAMPLE_BITS + FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [SUM_W-1:0]  in_sum,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ROOT_W-1:0] out_root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [ROOT_W-1:0] v_r;
  logic [ROOT_W-1:0] rdy;
  logic [ROOT_W-1:0] rdy_dn;
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_in;

  // Scale the sum by 4^FRAC_BITS
  assign rad_in = RAD_W'(in_sum) << (2 * FRAC_BITS);

  assign in_ready = rdy[0];
  assign rdy_dn[ROOT_W-1] = out_ready;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic              src_v;
    logic [RAD_W-1:0]  src_rad;
    logic [REM_W-1:0]  src_rem;
    logic [ROOT_W-1:0] src_root;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;
    logic [RAD_W-1:0]  rad_nxt;
    logic              v_nxt;

    // Select the stage source
    if (j == 0) begin : g_first
      assign src_v    = in_valid;
      assign src_rad  = rad_in;
      assign src_rem  = '0;
      assign src_root = '0;
    end else begin : g_next
      assign src_v    = v_r[j-1];
      assign src_rad  = rad_r[j-1];
      assign src_rem  = rem_r[j-1];
      assign src_root = root_r[j-1];
      assign rdy_dn[j-1] = rdy[j];
    end

    assign rdy[j] = !v_r[j] || rdy_dn[j];

    // Bring down two radicand bits, try the next root bit
    always_comb begin
      cur     = {src_rem[REM_W-3:0], src_rad[RAD_W-1 -: 2]};
      trial   = {src_root, 2'b01};
      rad_nxt = src_rad << 2;
      if (cur >= trial) begin
        rem_nxt  = cur - trial;
        root_nxt = {src_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = cur;
        root_nxt = {src_root[ROOT_W-2:0], 1'b0};
      end
      v_nxt = rdy[j] ? src_v : v_r[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else begin
        v_r[j] <= v_nxt;
      end
    end

    // Load payload on transfer into this stage
    always_ff @(posedge clk) begin
      if (rdy[j] && src_v) begin
        rad_r[j]  <= rad_nxt;
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];

endmodule

>>> rtl/avm_back.sv
// Output stage: vibration against the reference, saturation, result register.
`timescale 1ns / 1ps

module avm_back #(
  parameter int FRAC_BITS = avm_pkg::FRAC_BITS_DEF,
  parameter int ROOT_W    = avm_pkg::SAMPLE_BITS_DEF + avm_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ROOT_W-1:0]          in_root,
  input  logic [avm_pkg::GREF_W-1:0] gref,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [avm_pkg::OUT_W-1:0]  out_magnitude,
  output logic [avm_pkg::OUT_W-1:0]  out_vibration
);

  localparam int REF_W = avm_pkg::GREF_W + FRAC_BITS;
  localparam int CMP_W = (ROOT_W > REF_W) ? ROOT_W : REF_W;
  localparam int W     = (CMP_W > avm_pkg::OUT_W) ? CMP_W : avm_pkg::OUT_W;

  logic                      valid_r, valid_nxt;
  logic [avm_pkg::OUT_W-1:0] mag_r, mag_nxt;
  logic [avm_pkg::OUT_W-1:0] vib_r, vib_nxt;
  logic [W-1:0]              mag_w, ref_w, vib_w;

  assign in_ready = !valid_r || !out_stall;

  // Difference against the scaled reference, then saturate both fields
  always_comb begin
    mag_w = W'(in_root);
    ref_w = W'(gref) << FRAC_BITS;
    vib_w = (mag_w >= ref_w) ? (mag_w - ref_w) : (ref_w - mag_w);
    mag_nxt = (mag_w > W'(avm_pkg::OUT_MAX)) ? avm_pkg::OUT_MAX : mag_w[avm_pkg::OUT_W-1:0];
    vib_nxt = (vib_w > W'(avm_pkg::OUT_MAX)) ? avm_pkg::OUT_MAX : vib_w[avm_pkg::OUT_W-1:0];
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mag_r <= mag_nxt;
      vib_r <= vib_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_magnitude = mag_r;
  assign out_vibration = vib_r;

endmodule

>>> rtl/accel_vector_magnitude_unit.sv
// Path: front stages, one square-root stage per root bit, then the result register.
// Throughput: one sample per cycle while the output is not stalled.
// A full pipeline holds input stall only while every stage is full and the output is stalled.
// Reset (synchronous, rst_n low) clears all valid bits and sets the gravity reference to 16384.
// The configuration port is always ready.
`timescale 1ns / 1ps

module accel_vector_magnitude_unit #(
  parameter int FRAC_BITS   = avm_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = avm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [avm_pkg::IN_W-1:0]   in_axis_x,
  input  logic [avm_pkg::IN_W-1:0]   in_axis_y,
  input  logic [avm_pkg::IN_W-1:0]   in_axis_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [avm_pkg::OUT_W-1:0]  out_magnitude,
  output logic [avm_pkg::OUT_W-1:0]  out_vibration,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [avm_pkg::GREF_W-1:0] cfg_data
);

  localparam int SUM_W  = 2 * SAMPLE_BITS;
  localparam int ROOT_W = SAMPLE_BITS + FRAC_BITS;

  logic                       in_ready;
  logic                       fr_valid, fr_ready;
  logic [SUM_W-1:0]           fr_sum;
  logic                       sq_valid, sq_ready;
  logic [ROOT_W-1:0]          sq_root;
  logic [avm_pkg::GREF_W-1:0] gref_r, gref_nxt;

  // Gravity reference register
  assign cfg_ready = 1'b1;
  assign gref_nxt  = (cfg_valid && cfg_ready) ? cfg_data : gref_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gref_r <= avm_pkg::GREF_RESET;
    end else begin
      gref_r <= gref_nxt;
    end
  end

  assign in_stall = !in_ready;

  avm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .axis_x    (in_axis_x),
    .axis_y    (in_axis_y),
    .axis_z    (in_axis_z),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_sum   (fr_sum)
  );

  avm_sqrt #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .SUM_W       (SUM_W),
    .ROOT_W      (ROOT_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_sum    (fr_sum),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_root  (sq_root)
  );

  avm_back #(
    .FRAC_BITS (FRAC_BITS),
    .ROOT_W    (ROOT_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sq_valid),
    .in_ready      (sq_ready),
    .in_root       (sq_root),
    .gref          (gref_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_vibration (out_vibration)
  );

`ifndef SYNTHESIS
  // Input stall only propagates from a stalled, occupied output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Pipeline readies flow back to the output register
  a_back_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_valid && !sq_ready) |-> (out_valid && out_stall))
    else $error("square root held without a stalled result");
`endif

endmodule

>>> tb/accel_vector_magnitude_unit_tb.sv
// Self-checking testbench for the accelerometer vector magnitude unit.
`timescale 1ns / 1ps

module accel_vector_magnitude_unit_tb;

  localparam int LATENCY     = 4 + avm_pkg::SAMPLE_BITS_DEF + avm_pkg::FRAC_BITS_DEF;
  localparam int IDLE_PCT    = 55;
  localparam int LIGHT_PCT   = 8;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 220;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [avm_pkg::IN_W-1:0] x;
    logic [avm_pkg::IN_W-1:0] y;
    logic [avm_pkg::IN_W-1:0] z;
  } accel_sample_t;

  typedef struct packed {
    logic [avm_pkg::OUT_W-1:0] magnitude;
    logic [avm_pkg::OUT_W-1:0] vibration;
  } magnitude_result_t;

  // Ports of the block; every input that the bench drives is known from time zero
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [avm_pkg::IN_W-1:0]   in_axis_x = '0;
  logic [avm_pkg::IN_W-1:0]   in_axis_y = '0;
  logic [avm_pkg::IN_W-1:0]   in_axis_z = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [avm_pkg::OUT_W-1:0]  out_magnitude;
  logic [avm_pkg::OUT_W-1:0]  out_vibration;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [avm_pkg::GREF_W-1:0] cfg_data = '0;

  // Stimulus, prediction and bookkeeping
  accel_sample_t              pending_samples[$];
  magnitude_result_t          expected_results[$];
  logic [avm_pkg::GREF_W-1:0] gravity_ref_model = avm_pkg::GREF_RESET;
  int unsigned                sender_idle_pct = 0;
  int unsigned                receiver_stall_pct = 0;
  int unsigned                samples_loaded = 0;
  int unsigned                samples_sent = 0;
  int unsigned                results_checked = 0;
  int unsigned                ref_settings = 1;
  int unsigned                error_count = 0;

  accel_vector_magnitude_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_axis_x     (in_axis_x),
    .in_axis_y     (in_axis_y),
    .in_axis_z     (in_axis_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_vibration (out_vibration),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Square of one signed axis sample
  function automatic longint unsigned axis_square(input logic [avm_pkg::IN_W-1:0] raw);
    longint signed v;
    v = longint'($signed(raw));
    return longint'(v * v);
  endfunction

  // Exact floor(sqrt(sum * 4^FRAC_BITS)) and its distance from the scaled one-g reference, both saturated
  function automatic magnitude_result_t predict_magnitude(
    input accel_sample_t s,
    input logic [avm_pkg::GREF_W-1:0] gref
  );
    longint unsigned   scaled;
    longint unsigned   root;
    longint unsigned   trial;
    longint unsigned   ref_fx;
    longint unsigned   dev;
    magnitude_result_t r;
    scaled = (axis_square(s.x) + axis_square(s.y) + axis_square(s.z))
             << (2 * avm_pkg::FRAC_BITS_DEF);
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= scaled) begin
        root = trial;
      end
    end
    ref_fx = longint'(gref) << avm_pkg::FRAC_BITS_DEF;
    dev = (root >= ref_fx) ? root - ref_fx : ref_fx - root;
    r.magnitude = (root > avm_pkg::OUT_MAX) ? avm_pkg::OUT_MAX : root[avm_pkg::OUT_W-1:0];
    r.vibration = (dev > avm_pkg::OUT_MAX) ? avm_pkg::OUT_MAX : dev[avm_pkg::OUT_W-1:0];
    return r;
  endfunction

  function automatic bit roll_idle(input int unsigned pct);
    return (pct != 0) && ($urandom_range(99) < pct);
  endfunction

  // Mix full-range values with small ones, extremes and values near one g
  function automatic logic [avm_pkg::IN_W-1:0] random_axis();
    int unsigned pick;
    int signed   v;
    pick = $urandom_range(99);
    if (pick < 65) begin
      v = $urandom;
    end else if (pick < 77) begin
      v = $urandom_range(511) - 256;
    end else if (pick < 87) begin
      case ($urandom_range(4))
        0: v = -32768;
        1: v = 32767;
        2: v = -1;
        3: v = 1;
        default: v = 0;
      endcase
    end else begin
      v = 16384 + $urandom_range(64) - 32;
      if ($urandom_range(1)) begin
        v = -v;
      end
    end
    return v[avm_pkg::IN_W-1:0];
  endfunction

  task automatic load_sample(input logic [avm_pkg::IN_W-1:0] x,
                             input logic [avm_pkg::IN_W-1:0] y,
                             input logic [avm_pkg::IN_W-1:0] z);
    pending_samples.push_back('{x: x, y: y, z: z});
    samples_loaded++;
  endtask

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  // Hold until every loaded sample has been transferred and answered, then let the pipe settle
  task automatic drain_pipeline();
    do @(posedge clk); while (samples_sent != samples_loaded || expected_results.size() != 0);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_gravity_ref(input logic [avm_pkg::GREF_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gravity_ref_model = value;
    ref_settings++;
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        sender_idle_pct    = IDLE_PCT;
        receiver_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = IDLE_PCT;
      end
      IDLE_BOTH: begin
        sender_idle_pct    = LIGHT_PCT;
        receiver_stall_pct = LIGHT_PCT;
      end
      default: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
    endcase
  endtask

  task automatic run_random_phase(input logic [avm_pkg::GREF_W-1:0] gref,
                                  input idle_mode_t mode,
                                  input int unsigned count);
    write_gravity_ref(gref);
    set_idle(mode);
    for (int unsigned i = 0; i < count; i++) begin
      load_sample(random_axis(), random_axis(), random_axis());
    end
    drain_pipeline();
  endtask

  // Present the next sample once the current one has been transferred
  always @(posedge clk) begin : drive_samples
    accel_sample_t next;
    if (rst_n && (!in_valid || !in_stall)) begin
      if (pending_samples.size() != 0 && !roll_idle(sender_idle_pct)) begin
        next = pending_samples.pop_front();
        in_valid  <= 1'b1;
        in_axis_x <= next.x;
        in_axis_y <= next.y;
        in_axis_z <= next.z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= rst_n && roll_idle(receiver_stall_pct);
  end

  // Predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin : check_results
    magnitude_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_magnitude('{x: in_axis_x, y: in_axis_y,
                                                       z: in_axis_z}, gravity_ref_model));
        samples_sent++;
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("unexpected result magnitude=%0d vibration=%0d",
                               out_magnitude, out_vibration));
        end else begin
          want = expected_results.pop_front();
          if (out_magnitude !== want.magnitude) begin
            flag_error($sformatf("result %0d magnitude expected %0d actual %0d",
                                 results_checked, want.magnitude, out_magnitude));
          end
          if (out_vibration !== want.vibration) begin
            flag_error($sformatf("result %0d vibration expected %0d actual %0d",
                                 results_checked, want.vibration, out_vibration));
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed and random samples at the reset reference, no idling
    set_idle(IDLE_NONE);
    load_sample(16'h0000, 16'h0000, 16'h0000);
    load_sample(16'h8000, 16'h8000, 16'h8000);
    load_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    load_sample(16'h8000, 16'h7FFF, 16'h8000);
    load_sample(16'h8000, 16'h0000, 16'h0000);
    load_sample(16'h0000, 16'h7FFF, 16'h0000);
    load_sample(16'h0000, 16'h0000, 16'h4000);
    load_sample(16'h0000, 16'h0000, 16'hC000);
    load_sample(16'h4000, 16'h0000, 16'h0000);
    load_sample(16'h0000, 16'h4001, 16'h0000);
    load_sample(16'h3FFF, 16'h0000, 16'h0000);
    load_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    load_sample(16'h0001, 16'h0000, 16'h0000);
    load_sample(16'h0001, 16'h0001, 16'h0001);
    load_sample(16'h5555, 16'hAAAA, 16'h5555);
    load_sample(16'hAAAA, 16'h5555, 16'hAAAA);
    load_sample(16'h2000, 16'h2000, 16'h2000);
    load_sample(16'h0003, 16'h0004, 16'h0000);
    load_sample(16'hFFFD, 16'h0000, 16'hFFFC);
    load_sample(16'h1234, 16'hEDCC, 16'h0F0F);
    for (int i = 0; i < 150; i++) begin
      load_sample(random_axis(), random_axis(), random_axis());
    end
    drain_pipeline();

    // Reference extremes and ordinary values under each idle pattern
    run_random_phase(16'h0000, IDLE_SENDER, PHASE_ITEMS);
    run_random_phase(16'hFFFF, IDLE_RECEIVER, PHASE_ITEMS);
    run_random_phase(avm_pkg::GREF_W'($urandom), IDLE_BOTH, PHASE_ITEMS);
    run_random_phase(avm_pkg::GREF_RESET, IDLE_NONE, PHASE_ITEMS);
    run_random_phase(16'h0001, IDLE_RECEIVER, PHASE_ITEMS);

    if (expected_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_results.size()));
    end
    $display("Checked %0d results from %0d samples across %0d gravity reference settings",
             results_checked, samples_sent, ref_settings);
    $display("Idle patterns: none, sender gaps, receiver stalls, light gaps on both; errors: %0d",
             error_count);
    if (error_count == 0) begin
      $display("accel_vector_magnitude_unit_tb passed");
    end else begin
      $display("accel_vector_magnitude_unit_tb failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("Timeout with %0d results still expected", expected_results.size());
    $display("accel_vector_magnitude_unit_tb failed");
    $finish;
  end

endmodule

>>> files.f
rtl/avm_pkg.sv
rtl/avm_front.sv
rtl/avm_sqrt.sv
rtl/avm_back.sv
rtl/accel_vector_magnitude_unit.sv
tb/accel_vector_magnitude_unit_tb.sv
